>>> rtl/core/wskm_pkg.sv
// ----------------------------------------------------------------------------
// wskm_pkg - shared types and constants of the word-start key matcher
// Register map codes, character constants and the unit and character
// structs that travel between the top level and the match cells.
// ----------------------------------------------------------------------------
package wskm_pkg;

    localparam int KEY_REGS  = 4;   // 64-bit key byte registers
    localparam int KEY_BITS  = 64 * KEY_REGS;
    localparam int LEN_W     = 6;   // key_length register width
    localparam int CFG_W     = 64;  // APB data width
    localparam int ADDR_W    = 6;   // byte address, 8 bytes per register

    localparam logic [7:0] SPACE_CHAR    = 8'h20;
    localparam logic [7:0] LOW_CHAR_MAX  = 8'd127;

    typedef enum logic [2:0] {
        REG_KEY0    = 3'd0,
        REG_KEY1    = 3'd1,
        REG_KEY2    = 3'd2,
        REG_KEY3    = 3'd3,
        REG_KEY_LEN = 3'd4
    } t_reg_idx;

    // One key unit: one byte, or two bytes matched by a double character.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic       wide;
    } t_unit;

    // The character presented to every cell in a cycle.
    typedef struct packed {
        logic       kind;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_char;

endpackage

>>> rtl/core/wskm_in_if.sv
// ----------------------------------------------------------------------------
// wskm_in_if - character input channel
// Valid/ready channel carrying one text character or end-of-line marker.
// ----------------------------------------------------------------------------
interface wskm_in_if;
    logic       valid;
    logic       ready;
    logic       line_end;
    logic       char_kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;

    modport source (output valid, line_end, char_kind, first_byte, second_byte,
                    input ready);
    modport sink   (input valid, line_end, char_kind, first_byte, second_byte,
                    output ready);
endinterface

>>> rtl/core/wskm_out_if.sv
// ----------------------------------------------------------------------------
// wskm_out_if - match result channel
// Valid/ready channel carrying row, start column and length of one match.
// ----------------------------------------------------------------------------
interface wskm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] match_row;
    logic [11:0] match_column;
    logic [5:0]  match_chars;

    modport source (output valid, match_row, match_column, match_chars,
                    input ready);
    modport sink   (input valid, match_row, match_column, match_chars,
                    output ready);
endinterface

>>> rtl/core/wskm_cell.sv
// ----------------------------------------------------------------------------
// wskm_cell - one partial-match slot of the cell chain
// Holds the slot state (active, start column) and compares the current
// character against its key unit; the hit goes to the right neighbor.
// ----------------------------------------------------------------------------
module wskm_cell
    import wskm_pkg::*;
#(
    parameter int COL_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_init,
    input  logic             i_step,
    input  logic             i_load_active,
    input  logic [COL_W-1:0] i_load_start,
    input  t_unit            i_unit,
    input  logic             i_unit_en,
    input  t_char            i_char,
    output logic             o_hit,
    output logic [COL_W-1:0] o_start
);

    logic             r_active;
    logic [COL_W-1:0] r_start;
    logic             w_match;

    always_comb begin
        if (i_unit.wide) begin
            w_match = i_char.kind && (i_char.b0 == i_unit.b0) && (i_char.b1 == i_unit.b1);
        end else begin
            w_match = !i_char.kind && (i_char.b0 == i_unit.b0);
        end
    end

    assign o_hit   = r_active && i_unit_en && w_match;
    assign o_start = r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= i_init;
            r_start  <= '0;
        end else if (i_step) begin
            r_active <= i_load_active;
            r_start  <= i_load_start;
        end
    end

endmodule

>>> rtl/core/word_start_key_matcher.sv
// ----------------------------------------------------------------------------
// word_start_key_matcher - whole-word-prefix key search over a text stream
// Finds leftmost non-overlapping key occurrences that start a line or
// follow a single-byte space, one character per cycle while input is ready.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one transaction per character or end-of-line marker.
//   o_out  : one transaction per match (row, start column, length in chars).
//   APB    : key_bytes_0..3 at 0x00/0x08/0x10/0x18, key_length at 0x20,
//            64-bit data, pready tied high, registers read back.
// Throughput: one input transaction per cycle while i_in.ready is high. All
//   partial matches sit in a chain of MAX_KEY_BYTES cells, slot u holding a
//   match of u key units; each accepted character is compared by every cell,
//   which hands its hit to the next; a match result goes to the output buffer.
// Key decode: after reset and after each APB write the key is split into
//   units by a sequencer, one unit per cycle; i_in.ready is low meanwhile.
// Stall: a two-entry output buffer (output register plus skid) lets input
//   continue while one result waits; it stalls input only with both full.
// Reset (synchronous, i_rst_n low): row and column zero, line start,
//   no partial matches, key all zero with key_length 1.
// ----------------------------------------------------------------------------
module word_start_key_matcher
    import wskm_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32,
    parameter int LINE_CHARS    = 4096,
    parameter int MAX_LINES     = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wskm_in_if.sink           i_in,
    wskm_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam int COL_W   = $clog2(LINE_CHARS);
    localparam int ROW_W   = $clog2(MAX_LINES);
    localparam int IDX_W   = $clog2(MAX_KEY_BYTES);
    localparam int UNITS_W = $clog2(MAX_KEY_BYTES + 1);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_key [KEY_REGS];
    logic [LEN_W-1:0] r_len;
    logic             w_cfg_wr;
    t_reg_idx         w_idx;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (w_idx)
            REG_KEY0:    prdata = r_key[0];
            REG_KEY1:    prdata = r_key[1];
            REG_KEY2:    prdata = r_key[2];
            REG_KEY3:    prdata = r_key[3];
            REG_KEY_LEN: prdata = CFG_W'(r_len);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_REGS; i++) r_key[i] <= '0;
            r_len <= LEN_W'(1);
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_KEY0:    r_key[0] <= pwdata;
                REG_KEY1:    r_key[1] <= pwdata;
                REG_KEY2:    r_key[2] <= pwdata;
                REG_KEY3:    r_key[3] <= pwdata;
                REG_KEY_LEN: r_len    <= pwdata[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------- key unit decode sequencer ----------------
    // Walks the key bytes; each step emits one unit (one or two bytes).
    logic [KEY_BITS-1:0] w_key;
    logic [LEN_W-1:0]    w_len;
    logic                r_busy;
    logic [LEN_W-1:0]    r_b;
    logic [UNITS_W-1:0]  r_n;
    logic [UNITS_W-1:0]  r_units;
    t_unit               r_unit [MAX_KEY_BYTES];
    logic [7:0]          w_byte0;
    logic [7:0]          w_byte1;
    logic [4:0]          w_b_next;
    logic                w_wide;
    logic [LEN_W:0]      w_b_end;

    assign w_key    = {r_key[3], r_key[2], r_key[1], r_key[0]};
    assign w_len    = (r_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : r_len;
    assign w_b_next = r_b[4:0] + 5'd1;
    assign w_byte0  = w_key[{r_b[4:0], 3'b000} +: 8];
    assign w_byte1  = w_key[{w_b_next, 3'b000} +: 8];
    assign w_wide   = (w_byte0 > LOW_CHAR_MAX);
    assign w_b_end  = {1'b0, r_b} + (w_wide ? (LEN_W+1)'(2) : (LEN_W+1)'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_b     <= '0;
            r_n     <= '0;
            r_units <= '0;
        end else if (w_cfg_wr) begin
            r_busy <= 1'b1;
            r_b    <= '0;
            r_n    <= '0;
        end else if (r_busy) begin
            if (r_b >= w_len) begin
                r_units <= r_n;
                r_busy  <= 1'b0;
            end else if (w_b_end > {1'b0, w_len}) begin
                // lone trailing high byte: key can never match
                r_units <= '0;
                r_busy  <= 1'b0;
            end else begin
                r_b <= w_b_end[LEN_W-1:0];
                r_n <= r_n + UNITS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !w_cfg_wr && (r_b < w_len) && (w_b_end <= {1'b0, w_len})) begin
            r_unit[r_n[IDX_W-1:0]] <= '{b0: w_byte0, b1: w_byte1, wide: w_wide};
        end
    end

    // ---------------- input handshake ----------------
    logic  r_ov, r_sv;
    logic  w_accept, w_step_char, w_line_end;
    t_char w_char;

    assign i_in.ready  = !r_busy && !r_sv;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_line_end  = i_in.line_end;
    assign w_step_char = w_accept && !w_line_end;
    assign w_char      = '{kind: i_in.char_kind, b0: i_in.first_byte, b1: i_in.second_byte};

    // ---------------- cell chain ----------------
    logic [MAX_KEY_BYTES-1:0] w_hit;
    logic [MAX_KEY_BYTES-1:0] w_last;
    logic [MAX_KEY_BYTES-1:0] w_ld_act;
    logic [COL_W-1:0]         w_ld_start [MAX_KEY_BYTES];
    logic [COL_W-1:0]         w_start    [MAX_KEY_BYTES];
    logic                     w_done;
    logic [COL_W-1:0]         w_found;

    genvar u;
    generate
        for (u = 0; u < MAX_KEY_BYTES; u++) begin : g_cell
            if (u == 0) begin : g_head
                // slot 0 is the line-start/after-space flag; its start is the column
                assign w_ld_act[u] = w_line_end ||
                                     (!w_char.kind && (w_char.b0 == SPACE_CHAR));
                assign w_ld_start[u] = w_line_end ? '0 :
                    ((w_start[u] == COL_W'(LINE_CHARS - 1)) ? '0 :
                     w_start[u] + COL_W'(1));
            end else begin : g_body
                assign w_ld_act[u]   = !w_line_end && w_hit[u-1] && !w_done;
                assign w_ld_start[u] = w_start[u-1];
            end

            assign w_last[u] = (r_units == UNITS_W'(u + 1));

            wskm_cell #(
                .COL_W (COL_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_init        (u == 0),
                .i_step        (w_accept),
                .i_load_active (w_ld_act[u]),
                .i_load_start  (w_ld_start[u]),
                .i_unit        (r_unit[u]),
                .i_unit_en     (UNITS_W'(u) < r_units),
                .i_char        (w_char),
                .o_hit         (w_hit[u]),
                .o_start       (w_start[u])
            );
        end
    endgenerate

    always_comb begin
        w_found = '0;
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            if (w_hit[i] && w_last[i]) w_found = w_found | w_start[i];
        end
    end
    assign w_done = |(w_hit & w_last);

    // ---------------- row counter ----------------
    logic [ROW_W-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (w_accept && w_line_end) begin
            r_row <= (r_row == ROW_W'(MAX_LINES - 1)) ? '0 : r_row + ROW_W'(1);
        end
    end

    // ---------------- output buffer: register plus skid ----------------
    logic        w_push, w_pop;
    logic [33:0] w_res;
    logic [33:0] r_head, r_skid;

    assign w_push = w_step_char && w_done;
    assign w_pop  = r_ov && o_out.ready;
    assign w_res  = {16'(r_row), 12'(w_found), 6'(r_units)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || w_pop) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= w_push;
            end else begin
                r_ov <= w_push;
            end
        end else if (w_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || w_pop) begin
            r_head <= r_sv ? r_skid : w_res;
            if (r_sv) r_skid <= w_res;
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.match_row    = r_head[33:18];
    assign o_out.match_column = r_head[17:6];
    assign o_out.match_chars  = r_head[5:0];

    // ---------------- assertions ----------------
    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry without output entry");

    a_cfg_starts_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> r_busy)
        else $error("config write did not restart key decode");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> (r_ov && $stable(r_head)))
        else $error("stalled result lost or changed");

    a_done_has_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_units != '0))
        else $error("match reported with an empty key");

endmodule
